// ===== rtl/mmsm_pkg.sv =====
// Package for the mobility-management state machine: state codes, event codes
// and the packed item types of the input and result channels.
// No dependencies.
package mmsm_pkg;

  // machine states
  typedef enum logic [1:0] {
    ST_DEREG = 2'd0,
    ST_CPI   = 2'd1,
    ST_REG   = 2'd2,
    ST_DINIT = 2'd3
  } state_e;

  // event codes, 28..31 are unknown
  localparam logic [4:0] EV_REG_REQ        = 5'd0;
  localparam logic [4:0] EV_REG_ACC_NOTMR  = 5'd1;
  localparam logic [4:0] EV_REG_ACC_TMR    = 5'd2;
  localparam logic [4:0] EV_REG_CMPL       = 5'd3;
  localparam logic [4:0] EV_REG_REJ        = 5'd4;
  localparam logic [4:0] EV_UE_DEREG_REQ   = 5'd5;
  localparam logic [4:0] EV_NW_DEREG_INIT  = 5'd6;
  localparam logic [4:0] EV_DEREG_ACC      = 5'd7;
  localparam logic [4:0] EV_AUTH_REQ       = 5'd8;
  localparam logic [4:0] EV_AUTH_RSP       = 5'd9;
  localparam logic [4:0] EV_AUTH_FAIL      = 5'd10;
  localparam logic [4:0] EV_AUTH_REJ       = 5'd11;
  localparam logic [4:0] EV_SMC_SENT       = 5'd12;
  localparam logic [4:0] EV_SMC_CMPL       = 5'd13;
  localparam logic [4:0] EV_SMC_REJ        = 5'd14;
  localparam logic [4:0] EV_IDENT_REQ      = 5'd15;
  localparam logic [4:0] EV_IDENT_RSP      = 5'd16;
  localparam logic [4:0] EV_SVC_REQ        = 5'd17;
  localparam logic [4:0] EV_SVC_ACC        = 5'd18;
  localparam logic [4:0] EV_SVC_REJ        = 5'd19;
  localparam logic [4:0] EV_T3550_EXP      = 5'd20;
  localparam logic [4:0] EV_T3560_AUTH_EXP = 5'd21;
  localparam logic [4:0] EV_T3560_SMC_EXP  = 5'd22;
  localparam logic [4:0] EV_T3570_EXP      = 5'd23;
  localparam logic [4:0] EV_T3522_EXP      = 5'd24;
  localparam logic [4:0] EV_T3555_EXP      = 5'd25;
  localparam logic [4:0] EV_LL_FAIL        = 5'd26;
  localparam logic [4:0] EV_IMPL_DEREG     = 5'd27;

  // input item
  typedef struct packed {
    logic [4:0] opcode;
    logic       accept_timer_running;
    logic       initial_registration;
    logic       check_only;
  } mmsm_in_t;

  // result item
  typedef struct packed {
    logic       accepted;
    logic [1:0] from_state;
    logic [1:0] new_state;
  } mmsm_out_t;

endpackage

// ===== rtl/mmsm_decode.sv =====
// Transition table lookup for the mobility-management state machine.
// Pure combinational decode of one event against the current and prior state.
// Depends on mmsm_pkg.
module mmsm_decode import mmsm_pkg::*; (
  input  state_e    state_i,
  input  state_e    prior_i,
  input  mmsm_in_t  item_i,
  output mmsm_out_t result_o
);

  logic   hit;
  state_e next;
  logic   prior_reg;

  assign prior_reg = (prior_i == ST_REG);

  // first-match table, guards folded into each arm
  always_comb begin
    hit  = 1'b0;
    next = state_i;
    unique case (state_i)
      ST_DEREG: begin
        case (item_i.opcode) inside
          EV_REG_REQ, EV_AUTH_REQ, EV_SMC_SENT, EV_IDENT_REQ: begin
            hit  = 1'b1;
            next = ST_CPI;
          end
          EV_REG_ACC_NOTMR: begin
            hit  = 1'b1;
            next = ST_REG;
          end
          default: ;
        endcase
      end
      ST_CPI: begin
        case (item_i.opcode) inside
          EV_AUTH_REQ, EV_AUTH_RSP, EV_AUTH_FAIL, EV_SMC_SENT, EV_SMC_CMPL,
          EV_IDENT_REQ, EV_IDENT_RSP, EV_REG_REQ, EV_REG_ACC_TMR,
          EV_T3560_SMC_EXP: begin
            hit  = 1'b1;
            next = ST_CPI;
          end
          EV_REG_ACC_NOTMR, EV_REG_CMPL, EV_T3550_EXP: begin
            hit  = 1'b1;
            next = ST_REG;
          end
          EV_AUTH_REJ, EV_REG_REJ, EV_UE_DEREG_REQ, EV_SVC_REJ, EV_IMPL_DEREG: begin
            hit  = 1'b1;
            next = ST_DEREG;
          end
          // fall back to registered only if that was where we came from
          EV_T3560_AUTH_EXP, EV_T3570_EXP: begin
            hit  = 1'b1;
            next = prior_reg ? ST_REG : ST_DEREG;
          end
          EV_LL_FAIL: begin
            hit  = 1'b1;
            next = (item_i.accept_timer_running || prior_reg) ? ST_REG : ST_DEREG;
          end
          default: ;
        endcase
      end
      ST_REG: begin
        case (item_i.opcode) inside
          EV_REG_REQ, EV_AUTH_REQ, EV_SMC_SENT, EV_IDENT_REQ, EV_REG_ACC_TMR: begin
            hit  = 1'b1;
            next = ST_CPI;
          end
          EV_REG_CMPL, EV_SVC_REQ, EV_SVC_ACC, EV_T3555_EXP: begin
            hit  = 1'b1;
            next = ST_REG;
          end
          EV_UE_DEREG_REQ, EV_SVC_REJ, EV_IMPL_DEREG: begin
            hit  = 1'b1;
            next = ST_DEREG;
          end
          EV_NW_DEREG_INIT: begin
            hit  = 1'b1;
            next = ST_DINIT;
          end
          default: ;
        endcase
      end
      ST_DINIT: begin
        case (item_i.opcode) inside
          EV_DEREG_ACC, EV_T3522_EXP, EV_LL_FAIL, EV_UE_DEREG_REQ, EV_IMPL_DEREG: begin
            hit  = 1'b1;
            next = ST_DEREG;
          end
          // only an initial registration restarts procedures here
          EV_REG_REQ: begin
            hit  = item_i.initial_registration;
            next = item_i.initial_registration ? ST_CPI : ST_DINIT;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o.accepted   = hit;
  assign result_o.from_state = state_i;
  assign result_o.new_state  = next;

endmodule

// ===== rtl/mobility_mgmt_state_machine_core.sv =====
// Mobility-management state machine, network side.
// Result path: input register, then result register.
// Throughput: one item per cycle when not stalled; the state registers update as an
// accepted, non-check-only item moves into the result register, so the next item sees it.
// Reset (async, active low) empties both stages and sets current and prior
// state to deregistered.
module mobility_mgmt_state_machine_core import mmsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mmsm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mmsm_out_t out_data_o
);

  logic      in_valid_q;
  mmsm_in_t  in_item_q;
  logic      out_valid_q;
  mmsm_out_t out_item_q;
  state_e    state_q;
  state_e    prior_q;
  mmsm_out_t dec;
  logic      out_free;
  logic      fire;
  logic      commit;

  // handshake between the two stages
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign commit     = fire && dec.accepted && !in_item_q.check_only;

  mmsm_decode u_decode (
    .state_i  (state_q),
    .prior_i  (prior_q),
    .item_i   (in_item_q),
    .result_o (dec)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= dec;
    end
  end

  // machine state, prior state kept on entry to common procedure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DEREG;
      prior_q <= ST_DEREG;
    end else if (commit) begin
      state_q <= state_e'(dec.new_state);
      if (state_e'(dec.new_state) == ST_CPI && state_q != ST_CPI) begin
        prior_q <= state_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // a rejected event reports no state change
  a_reject_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.accepted |-> out_item_q.new_state == out_item_q.from_state)
    else $error("rejected item reports a state change");

  // a committed transition lands in the state register
  a_commit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> state_q == state_e'($past(dec.new_state)))
    else $error("state register missed a committed transition");

  // check-only items leave both state registers alone
  a_check_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_item_q.check_only |=> $stable(state_q) && $stable(prior_q))
    else $error("check-only item changed stored state");

  // prior state is never common procedure
  a_prior_not_cpi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prior_q != ST_CPI)
    else $error("prior state holds common procedure");

endmodule
